FILE: rtl/tse_pkg.sv
// Package for the TFTP transfer session engine.
// Holds the channel payload types, protocol codes and length limits.
// No dependencies; every other file in rtl/ takes names from here.
package tse_pkg;

   // Payload size of a full DATA block in bytes
   localparam int BLOCK_BYTES = 512;

   // Length caps, widened by one bit so that any BLOCK_BYTES up to 1024 compares cleanly
   localparam logic [10:0] LEN_CAP   = 11'(BLOCK_BYTES + 4);
   localparam logic [10:0] CHUNK_CAP = 11'(BLOCK_BYTES);

   localparam logic [7:0] RETRY_LIMIT_RESET = 8'd10;

   // Item kinds
   localparam logic [1:0] REQ_NEW    = 2'd0;
   localparam logic [1:0] REQ_PKT    = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // TFTP opcodes
   localparam logic [15:0] OP_RRQ  = 16'd1;
   localparam logic [15:0] OP_WRQ  = 16'd2;
   localparam logic [15:0] OP_DATA = 16'd3;
   localparam logic [15:0] OP_ACK  = 16'd4;
   localparam logic [15:0] OP_ERR  = 16'd5;

   // Transfer modes
   localparam logic [1:0] MODE_NONE    = 2'd0;
   localparam logic [1:0] MODE_UNKNOWN = 2'd0;
   localparam logic [1:0] MODE_RESVD   = 2'd3;

   // Actions
   localparam logic [2:0] ACT_NONE  = 3'd0;
   localparam logic [2:0] ACT_DATA  = 3'd1;
   localparam logic [2:0] ACT_ACK   = 3'd2;
   localparam logic [2:0] ACT_ERR   = 3'd3;
   localparam logic [2:0] ACT_ABORT = 3'd4;

   // Error codes on the wire
   localparam logic ERRC_UNDEF    = 1'b0;
   localparam logic ERRC_NOTFOUND = 1'b1;

   // Error message kinds
   localparam logic [3:0] K_SIZE     = 4'd0;
   localparam logic [3:0] K_OPCODE   = 4'd1;
   localparam logic [3:0] K_NAME     = 4'd2;
   localparam logic [3:0] K_NOMODE   = 4'd3;
   localparam logic [3:0] K_NOTFOUND = 4'd4;
   localparam logic [3:0] K_BADMODE  = 4'd5;
   localparam logic [3:0] K_BLOCK    = 4'd6;
   localparam logic [3:0] K_UNEXP    = 4'd7;
   localparam logic [3:0] K_ACK      = 4'd8;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] pkt_opcode;
      logic [15:0] pkt_block;
      logic [9:0]  pkt_len;
      logic        name_terminated;
      logic        mode_present;
      logic        file_opened;
      logic [1:0]  mode_code;
      logic [9:0]  chunk_len;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] block_num;
      logic [9:0]  data_len;
      logic        error_code;
      logic [3:0]  error_kind;
      logic        session_done;
      logic [1:0]  transfer_mode;
   } rsp_payload_type;

endpackage

FILE: rtl/tse_req_if.sv
// Request channel of the TFTP transfer session engine: valid/ready plus header payload.
// Depends on tse_pkg for the payload type.
interface tse_req_if;
   logic                      valid;
   logic                      ready;
   tse_pkg::req_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/tse_rsp_if.sv
// Response channel of the TFTP transfer session engine: valid/ready plus action payload.
// Depends on tse_pkg for the payload type.
interface tse_rsp_if;
   logic                      valid;
   logic                      ready;
   tse_pkg::rsp_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/tftp_transfer_session_engine_core.sv
// TFTP transfer session engine. Takes one event per transfer on req_chan (a request
// header, a client packet header or a timeout tick) and returns exactly one action on
// rsp_chan: nothing, send DATA, send ACK, send ERROR, or abort. Throughput is one item
// per clock while rsp_chan is not held off. An accepted item sits in the input register
// and moves into the result register, from which it is offered on rsp_chan. The session
// state is updated as the item moves into the result register.
// While rsp_chan is held off, both registers fill and req_chan.ready drops.
// csr_wr_data sets the timeout retry limit (reset 10, 0 acts as 1); write it only while
// no item is in flight.
// Depends on tse_pkg, tse_req_if and tse_rsp_if.
module tftp_transfer_session_engine_core (
   input  logic        clock,
   input  logic        reset,
   tse_req_if.sink     req_chan,
   tse_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_READ  = 2'd1,
      PH_WRITE = 2'd2
   } phase_type;

   // Input register
   logic                      s1_valid_ff;
   tse_pkg::req_payload_type  s1_data_ff;

   // Result register
   logic                      rsp_valid_ff;
   tse_pkg::rsp_payload_type  rsp_data_ff;
   tse_pkg::rsp_payload_type  rsp_data_in;

   // Session state
   phase_type    phase_ff,         phase_in;
   logic [15:0]  block_counter_ff, block_counter_in;
   logic [7:0]   retries_left_ff,  retries_left_in;
   logic         final_block_ff,   final_block_in;
   logic [1:0]   session_mode_ff,  session_mode_in;
   logic [9:0]   pending_len_ff,   pending_len_in;
   logic [7:0]   retry_limit_ff;

   logic         advance;
   logic [9:0]   len_sat;
   logic [9:0]   chunk_sat;
   logic         chunk_short;
   logic         len_short;
   logic [7:0]   fresh_retries;
   logic [7:0]   retries_dec;
   logic [15:0]  block_next;
   logic         req_err;
   logic [3:0]   req_kind;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Clamp oversized lengths
   assign len_sat = ({1'b0, s1_data_ff.pkt_len} > tse_pkg::LEN_CAP) ?
                    tse_pkg::LEN_CAP[9:0] : s1_data_ff.pkt_len;
   assign chunk_sat = ({1'b0, s1_data_ff.chunk_len} > tse_pkg::CHUNK_CAP) ?
                      tse_pkg::CHUNK_CAP[9:0] : s1_data_ff.chunk_len;
   assign chunk_short = {1'b0, chunk_sat} < tse_pkg::CHUNK_CAP;
   assign len_short   = {1'b0, len_sat} < tse_pkg::LEN_CAP;

   assign fresh_retries = (retry_limit_ff == 8'd0) ? 8'd1 : retry_limit_ff;
   assign retries_dec   = (retries_left_ff != 8'd0) ? retries_left_ff - 8'd1 : retries_left_ff;
   assign block_next    = block_counter_ff + 16'd1;

   // Request checks, first failure wins
   always_comb begin
      req_err  = 1'b1;
      req_kind = tse_pkg::K_SIZE;
      if (len_sat < 10'd4) begin
         req_kind = tse_pkg::K_SIZE;
      end else if (s1_data_ff.pkt_opcode != tse_pkg::OP_RRQ &&
                   s1_data_ff.pkt_opcode != tse_pkg::OP_WRQ) begin
         req_kind = tse_pkg::K_OPCODE;
      end else if (!s1_data_ff.name_terminated) begin
         req_kind = tse_pkg::K_NAME;
      end else if (!s1_data_ff.mode_present) begin
         req_kind = tse_pkg::K_NOMODE;
      end else if (!s1_data_ff.file_opened) begin
         req_kind = tse_pkg::K_NOTFOUND;
      end else if (s1_data_ff.mode_code == tse_pkg::MODE_UNKNOWN ||
                   s1_data_ff.mode_code == tse_pkg::MODE_RESVD) begin
         req_kind = tse_pkg::K_BADMODE;
      end else begin
         req_err = 1'b0;
      end
   end

   // Session step
   always_comb begin
      phase_in         = phase_ff;
      block_counter_in = block_counter_ff;
      retries_left_in  = retries_left_ff;
      final_block_in   = final_block_ff;
      session_mode_in  = session_mode_ff;
      pending_len_in   = pending_len_ff;
      rsp_data_in      = '0;

      if (s1_data_ff.req_type == tse_pkg::REQ_NEW) begin
         // Any running session is dropped
         phase_in        = PH_IDLE;
         session_mode_in = tse_pkg::MODE_NONE;
         if (req_err) begin
            rsp_data_in.action     = tse_pkg::ACT_ERR;
            rsp_data_in.error_kind = req_kind;
            rsp_data_in.error_code = (req_kind == tse_pkg::K_NOTFOUND) ?
                                     tse_pkg::ERRC_NOTFOUND : tse_pkg::ERRC_UNDEF;
         end else begin
            session_mode_in           = s1_data_ff.mode_code;
            retries_left_in           = fresh_retries;
            rsp_data_in.transfer_mode = s1_data_ff.mode_code;
            if (s1_data_ff.pkt_opcode == tse_pkg::OP_WRQ) begin
               phase_in              = PH_WRITE;
               block_counter_in      = 16'd0;
               final_block_in        = 1'b0;
               pending_len_in        = 10'd0;
               rsp_data_in.action    = tse_pkg::ACT_ACK;
            end else begin
               phase_in              = PH_READ;
               block_counter_in      = 16'd1;
               pending_len_in        = chunk_sat;
               final_block_in        = chunk_short;
               rsp_data_in.action    = tse_pkg::ACT_DATA;
               rsp_data_in.block_num = 16'd1;
               rsp_data_in.data_len  = chunk_sat;
            end
         end
      end else if ((phase_ff != PH_READ && phase_ff != PH_WRITE) ||
                   s1_data_ff.req_type == tse_pkg::REQ_UNUSED) begin
         rsp_data_in = '0;
      end else begin
         rsp_data_in.transfer_mode = session_mode_ff;
         if (s1_data_ff.req_type == tse_pkg::REQ_TICK) begin
            retries_left_in = retries_dec;
            if (retries_dec == 8'd0) begin
               // Out of retries: drop without a final send
               phase_in           = PH_IDLE;
               session_mode_in    = tse_pkg::MODE_NONE;
               rsp_data_in.action = tse_pkg::ACT_ABORT;
            end else if (phase_ff == PH_READ) begin
               rsp_data_in.action    = tse_pkg::ACT_DATA;
               rsp_data_in.block_num = block_counter_ff;
               rsp_data_in.data_len  = pending_len_ff;
            end else begin
               rsp_data_in.action    = tse_pkg::ACT_ACK;
               rsp_data_in.block_num = block_counter_ff;
            end
         end else if (len_sat < 10'd4) begin
            phase_in               = PH_IDLE;
            session_mode_in        = tse_pkg::MODE_NONE;
            rsp_data_in.action     = tse_pkg::ACT_ERR;
            rsp_data_in.error_kind = tse_pkg::K_SIZE;
         end else if (phase_ff == PH_READ) begin
            if (s1_data_ff.pkt_opcode == tse_pkg::OP_ERR) begin
               phase_in           = PH_IDLE;
               session_mode_in    = tse_pkg::MODE_NONE;
               rsp_data_in.action = tse_pkg::ACT_ABORT;
            end else if (s1_data_ff.pkt_opcode != tse_pkg::OP_ACK) begin
               phase_in               = PH_IDLE;
               session_mode_in        = tse_pkg::MODE_NONE;
               rsp_data_in.action     = tse_pkg::ACT_ERR;
               rsp_data_in.error_kind = tse_pkg::K_UNEXP;
            end else if (s1_data_ff.pkt_block != block_counter_ff) begin
               phase_in               = PH_IDLE;
               session_mode_in        = tse_pkg::MODE_NONE;
               rsp_data_in.action     = tse_pkg::ACT_ERR;
               rsp_data_in.error_kind = tse_pkg::K_ACK;
            end else if (final_block_ff) begin
               phase_in                 = PH_IDLE;
               session_mode_in          = tse_pkg::MODE_NONE;
               rsp_data_in.action       = tse_pkg::ACT_NONE;
               rsp_data_in.session_done = 1'b1;
            end else begin
               // Advance to the next block
               block_counter_in      = block_next;
               pending_len_in        = chunk_sat;
               final_block_in        = chunk_short;
               retries_left_in       = fresh_retries;
               rsp_data_in.action    = tse_pkg::ACT_DATA;
               rsp_data_in.block_num = block_next;
               rsp_data_in.data_len  = chunk_sat;
            end
         end else begin
            if (s1_data_ff.pkt_block != block_next) begin
               phase_in               = PH_IDLE;
               session_mode_in        = tse_pkg::MODE_NONE;
               rsp_data_in.action     = tse_pkg::ACT_ERR;
               rsp_data_in.error_kind = tse_pkg::K_BLOCK;
            end else if (s1_data_ff.pkt_opcode != tse_pkg::OP_DATA) begin
               phase_in               = PH_IDLE;
               session_mode_in        = tse_pkg::MODE_NONE;
               rsp_data_in.action     = tse_pkg::ACT_ERR;
               rsp_data_in.error_kind = tse_pkg::K_UNEXP;
            end else begin
               block_counter_in         = block_next;
               retries_left_in          = fresh_retries;
               final_block_in           = len_short;
               pending_len_in           = len_sat - 10'd4;
               rsp_data_in.action       = tse_pkg::ACT_ACK;
               rsp_data_in.block_num    = block_next;
               rsp_data_in.data_len     = len_sat - 10'd4;
               rsp_data_in.session_done = len_short;
               // A short block closes the session on its ACK
               if (len_short) begin
                  phase_in        = PH_IDLE;
                  session_mode_in = tse_pkg::MODE_NONE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         phase_ff         <= PH_IDLE;
         block_counter_ff <= 16'd0;
         retries_left_ff  <= 8'd0;
         final_block_ff   <= 1'b0;
         session_mode_ff  <= tse_pkg::MODE_NONE;
         pending_len_ff   <= 10'd0;
         retry_limit_ff   <= tse_pkg::RETRY_LIMIT_RESET;
      end else begin
         if (csr_wr_en) begin
            retry_limit_ff <= csr_wr_data;
         end
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff     <= 1'b1;
            rsp_data_ff      <= rsp_data_in;
            phase_ff         <= phase_in;
            block_counter_ff <= block_counter_in;
            retries_left_ff  <= retries_left_in;
            final_block_ff   <= final_block_in;
            session_mode_ff  <= session_mode_in;
            pending_len_ff   <= pending_len_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Input payload register
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_data_ff <= req_chan.payload;
      end
   end

`ifndef SYNTHESIS
   // A session has a mode exactly while it runs
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) == (session_mode_ff == tse_pkg::MODE_NONE))
      else $error("session mode out of step with phase");

   // A running session always has at least one retry in hand
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (retries_left_ff != 8'd0))
      else $error("session running with no retries left");

   // ERROR and abort both end the session
   assert property (@(posedge clock) disable iff (reset)
      (advance && (rsp_data_in.action == tse_pkg::ACT_ERR ||
                   rsp_data_in.action == tse_pkg::ACT_ABORT)) |=> (phase_ff == PH_IDLE))
      else $error("session survived an ERROR or abort");

   // A held item stays in the input register until it moves on
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff)
      else $error("accepted item lost from input register");

   // Outgoing DATA never exceeds one block
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.action == tse_pkg::ACT_DATA) |->
      ({1'b0, rsp_data_ff.data_len} <= tse_pkg::CHUNK_CAP))
      else $error("DATA length above block size");
`endif

endmodule
